/* rtl/core/gps_to_local_mercator_macros.svh */
// Assertion macros for the Mercator projection RTL.
`ifndef GPS_TO_LOCAL_MERCATOR_MACROS_SVH
`define GPS_TO_LOCAL_MERCATOR_MACROS_SVH
`ifndef SYNTH
`define GTLM_ASSERT(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);
`define GTLM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define GTLM_ASSERT(lbl, clk, rstn, cond, msg)
`define GTLM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

/* rtl/core/gtlm_pkg.sv */
// Types, constants and table generators for the Mercator projection block.
package gtlm_pkg;

  localparam logic [63:0] PI_Q62      = 64'hC90FDAA22168C235;
  localparam logic [63:0] HALF_PI_Q40 = PI_Q62 >> 23;
  localparam logic [63:0] MM_K_FULL   =
    ((64'd6378137 * (PI_Q62 >> 28)) / 64'd1800000) >> 8;
  localparam logic [31:0] MM_PER_E7_Q26 = MM_K_FULL[31:0];
  localparam logic [22:0] EARTH_R_M     = 23'd6378137;
  localparam logic [9:0]  THOUSAND      = 10'd1000;
  localparam logic [29:0] LAT_LIMIT_E7  = 30'd850511287;
  // 90 degrees in 1e-7 units is 2^8 times this odd factor
  localparam logic [21:0] LAT_DIV_ODD   = 22'd3515625;
  localparam int unsigned RECIP_SHIFT   = 52;
  localparam int unsigned GD_W  = 44;
  localparam int unsigned MAG_W = 36;
  localparam logic signed [37:0] LIM_HORIZ = 38'sd40100000000;
  localparam logic signed [28:0] LIM_UP    = 29'sd101000000;

  typedef struct packed {
    logic               lat_neg;
    logic [29:0]        lat_mag;
    logic               oor;
    logic               lon_neg;
    logic [31:0]        lon_mag;
    logic signed [27:0] alt;
  } item_t;

  typedef enum logic [3:0] {
    B_IDLE, B_MPOS, B_ROM0, B_ROM1, B_ROM2, B_ROM3, B_MCOS, B_MGD,
    B_MR, B_M1K, B_MNS, B_MLON, B_MES, B_FIN
  } back_state_e;

  typedef enum logic [1:0] {M_IDLE, M_LO, M_HI, M_SUM} mul_step_e;

  // Taylor term divisor (2n-1)*2n
  function automatic logic [63:0] fact_div(input logic [63:0] t, input int unsigned n);
    case (n)
      1:       return t / 64'd2;
      2:       return t / 64'd12;
      3:       return t / 64'd30;
      4:       return t / 64'd56;
      5:       return t / 64'd90;
      6:       return t / 64'd132;
      7:       return t / 64'd182;
      8:       return t / 64'd240;
      9:       return t / 64'd306;
      10:      return t / 64'd380;
      11:      return t / 64'd462;
      12:      return t / 64'd552;
      13:      return t / 64'd650;
      14:      return t / 64'd756;
      default: return t;
    endcase
  endfunction

  // cosine in Q30 at m steps of (pi/2)/2^(tb+1)
  function automatic logic [63:0] cos_fine(input logic [31:0] m, input int unsigned tb);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    x    = ({32'b0, m} * HALF_PI_Q40) >> (tb + 11);
    x2   = (x * x) >> 30;
    term = 64'd1 << 30;
    sum  = longint'(term);
    for (int unsigned n = 1; n <= 14; n++) begin
      term = fact_div((term * x2) >> 30, n);
      if (n % 2 == 1) sum = sum - longint'(term);
      else            sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > longint'(64'd1 << 30)) sum = longint'(64'd1 << 30);
    return 64'(sum);
  endfunction

  // 2^50 / c, restoring long division
  function automatic logic [63:0] inv_q20(input logic [63:0] c);
    logic [63:0] den;
    logic [63:0] r;
    logic [63:0] q;
    den = (c < 64'd1024) ? 64'd1024 : c;
    r   = '0;
    q   = '0;
    for (int b = 50; b >= 0; b--) begin
      r = (r << 1) | ((b == 50) ? 64'd1 : 64'd0);
      if (r >= den) begin
        r    = r - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

endpackage

/* rtl/core/gtlm_front.sv */
// Front end: takes a fix transfer, clamps latitude and splits signs from magnitudes.
module gtlm_front (
  input  logic           s_axis_tvalid_i,
  output logic           s_axis_tready_o,
  input  logic [95:0]    s_axis_tdata_i,   // latitude_e7, longitude_e7, altitude_mm
  output logic           item_valid_o,
  output gtlm_pkg::item_t item_o,
  input  logic           item_full_i
);
  import gtlm_pkg::*;

  logic [30:0] lat;
  logic [31:0] lon;
  logic [30:0] lat_abs;
  logic        oor;

  assign lat     = s_axis_tdata_i[30:0];
  assign lon     = s_axis_tdata_i[62:31];
  assign lat_abs = lat[30] ? (~lat + 31'd1) : lat;
  assign oor     = lat_abs > {1'b0, LAT_LIMIT_E7};

  always_comb begin
    item_o.lat_neg = lat[30];
    item_o.lat_mag = oor ? LAT_LIMIT_E7 : lat_abs[29:0];
    item_o.oor     = oor;
    item_o.lon_neg = lon[31];
    item_o.lon_mag = lon[31] ? (~lon + 32'd1) : lon;
    item_o.alt     = s_axis_tdata_i[90:63];
  end

  assign item_valid_o    = s_axis_tvalid_i;
  assign s_axis_tready_o = !item_full_i;

endmodule

/* rtl/core/gtlm_fifo.sv */
// Two-entry queue between front and back end.
module gtlm_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  gtlm_pkg::item_t data_i,
  output logic            full_o,
  output logic            valid_o,
  output gtlm_pkg::item_t data_o,
  input  logic            pop_i
);
  import gtlm_pkg::*;

  item_t       mem_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;
  logic        do_push, do_pop;

  assign full_o  = count_q == 2'd2;
  assign valid_o = count_q != 2'd0;
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    count_d  = count_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

/* rtl/core/gtlm_mul.sv */
// Shared 64x32 multiplier built from one 32x32 multiplier, used for the low and then the high half.
module gtlm_mul (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] a_i,
  input  logic [31:0] b_i,
  output logic        done_o,
  output logic [95:0] p_o
);
  import gtlm_pkg::*;

  mul_step_e   step_q, step_d;
  logic        done_q, done_d;
  logic [63:0] a_q;
  logic [31:0] b_q;
  logic [31:0] half;
  logic [63:0] prod_q;
  logic [95:0] acc_q;

  always_comb begin
    step_d = step_q;
    done_d = 1'b0;
    case (step_q)
      M_IDLE: if (start_i) step_d = M_LO;
      M_LO:   step_d = M_HI;
      M_HI:   step_d = M_SUM;
      M_SUM: begin
        step_d = M_IDLE;
        done_d = 1'b1;
      end
      default: step_d = M_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= M_IDLE;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      done_q <= done_d;
    end
  end

  assign half = (step_q == M_LO) ? a_q[31:0] : a_q[63:32];

  always_ff @(posedge clk_i) begin
    if (start_i && step_q == M_IDLE) begin
      a_q <= a_i;
      b_q <= b_i;
    end
    prod_q <= {32'b0, half} * {32'b0, b_q};
    if (step_q == M_HI)  acc_q <= {32'b0, prod_q};
    if (step_q == M_SUM) acc_q <= acc_q + {prod_q, 32'b0};
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule

/* rtl/core/gtlm_back.sv */
// Back end: latitude scaling, table lookup, shared-multiplier sequencer, output register.
`include "gps_to_local_mercator_macros.svh"
module gtlm_back #(
  parameter int unsigned TABLE_BITS = 10
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            item_valid_i,
  input  gtlm_pkg::item_t item_i,
  output logic            item_pop_o,
  output logic            m_axis_tvalid_o,
  input  logic            m_axis_tready_i,
  output logic [103:0]    m_axis_tdata_o,   // right_mm, up_mm, forward_mm
  output logic [1:0]      m_axis_tuser_o    // is_origin, out_of_range
);
  import gtlm_pkg::*;

  localparam int unsigned TSIZE = 1 << TABLE_BITS;
  localparam int unsigned POS_W = TABLE_BITS + 16;
  localparam logic [TABLE_BITS-1:0] IDX_MAX = TABLE_BITS'(TSIZE - 2);
  // ceil(2^(52+TABLE_BITS+8) / odd factor): exact floor quotient for 30-bit latitudes
  localparam logic [127:0] RECIP_FULL =
    ((128'd1 << (RECIP_SHIFT + TABLE_BITS + 8)) + {106'b0, LAT_DIV_ODD} - 128'd1)
    / {106'b0, LAT_DIV_ODD};
  localparam logic [63:0] POS_RECIP = RECIP_FULL[63:0];

  typedef logic [31:0]     cos_rom_t [TSIZE];
  typedef logic [GD_W-1:0] gd_rom_t  [TSIZE];

  function automatic cos_rom_t build_cos();
    cos_rom_t    rom;
    logic [63:0] c;
    for (int unsigned k = 0; k < TSIZE; k++) begin
      c = cos_fine(32'(2 * k), TABLE_BITS) << 1;
      if (c > (64'd1 << 31)) c = 64'd1 << 31;
      rom[k] = c[31:0];
    end
    return rom;
  endfunction

  // Simpson integration of sec(x)
  function automatic gd_rom_t build_gd();
    gd_rom_t     rom;
    logic [63:0] h;
    logic [63:0] s;
    logic [63:0] acc;
    h      = HALF_PI_Q40 >> TABLE_BITS;
    acc    = '0;
    rom[0] = '0;
    for (int unsigned k = 0; k + 1 < TSIZE; k++) begin
      s = inv_q20(cos_fine(32'(2 * k), TABLE_BITS))
        + 64'd4 * inv_q20(cos_fine(32'(2 * k + 1), TABLE_BITS))
        + inv_q20(cos_fine(32'(2 * k + 2), TABLE_BITS));
      acc        = acc + (((s * h) / 64'd6) >> 20);
      rom[k + 1] = acc[GD_W-1:0];
    end
    return rom;
  endfunction

  localparam cos_rom_t COS_ROM = build_cos();
  localparam gd_rom_t  GD_ROM  = build_gd();

  back_state_e state_q, state_d;
  item_t       item_q, item_d;
  logic [POS_W-1:0] quo_q, quo_d;
  logic [TABLE_BITS-1:0] idx_q, idx_d;
  logic [15:0] frac_q, frac_d;
  logic [31:0] cos_a_q, cos_a_d, cos_b_q, cos_b_d, cos_rd_q;
  logic [GD_W-1:0] gd_a_q, gd_a_d, gd_b_q, gd_b_d, gd_rd_q;
  logic [31:0] scale_q, scale_d;
  logic [GD_W-1:0] g_q, g_d;
  logic [63:0] tmp_q, tmp_d;
  logic [MAG_W-1:0] north_q, north_d, east_q, east_d;
  logic        origin_valid_q, origin_valid_d;
  logic signed [36:0] org_n_q, org_n_d, org_e_q, org_e_d;
  logic signed [27:0] org_u_q, org_u_d;
  logic        mul_busy_q, mul_busy_d;
  logic        out_valid_q, out_valid_d;
  logic [36:0] out_right_q, out_fwd_q;
  logic [27:0] out_up_q;
  logic        out_first_q, out_oor_q;
  logic        out_load;

  logic        mul_start, mul_done;
  logic [63:0] mul_a;
  logic [31:0] mul_b;
  logic [95:0] mul_p;

  logic [TABLE_BITS-1:0] rom_addr;
  logic [TABLE_BITS-1:0] ipos;
  logic        cos_up, gd_up;
  logic [31:0] cdiff;
  logic [GD_W-1:0] gdiff;
  logic [64:0] ns_sum, es_sum;
  logic signed [36:0] north_s, east_s, on_s, oe_s;
  logic signed [27:0] ou_s;
  logic signed [37:0] right_full, fwd_full, right_sat, fwd_sat;
  logic signed [28:0] up_full, up_sat;

  gtlm_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  assign rom_addr = idx_q + TABLE_BITS'(state_q == B_ROM2);
  assign ipos     = quo_q[POS_W-1:16];
  assign cos_up   = cos_b_q >= cos_a_q;
  assign gd_up    = gd_b_q >= gd_a_q;
  assign cdiff    = cos_up ? (cos_b_q - cos_a_q) : (cos_a_q - cos_b_q);
  assign gdiff    = gd_up ? (gd_b_q - gd_a_q) : (gd_a_q - gd_b_q);
  assign ns_sum   = mul_p[95:31] + 65'd32768;
  assign es_sum   = mul_p[95:31] + (65'd1 << 25);

  assign north_s = item_q.lat_neg ? -$signed({1'b0, north_q}) : $signed({1'b0, north_q});
  assign east_s  = item_q.lon_neg ? -$signed({1'b0, east_q}) : $signed({1'b0, east_q});
  assign on_s    = origin_valid_q ? org_n_q : north_s;
  assign oe_s    = origin_valid_q ? org_e_q : east_s;
  assign ou_s    = origin_valid_q ? org_u_q : item_q.alt;

  assign right_full = {on_s[36], on_s} - {north_s[36], north_s};
  assign fwd_full   = {east_s[36], east_s} - {oe_s[36], oe_s};
  assign up_full    = {item_q.alt[27], item_q.alt} - {ou_s[27], ou_s};
  assign right_sat  = (right_full > LIM_HORIZ) ? LIM_HORIZ :
                      (right_full < -LIM_HORIZ) ? -LIM_HORIZ : right_full;
  assign fwd_sat    = (fwd_full > LIM_HORIZ) ? LIM_HORIZ :
                      (fwd_full < -LIM_HORIZ) ? -LIM_HORIZ : fwd_full;
  assign up_sat     = (up_full > LIM_UP) ? LIM_UP :
                      (up_full < -LIM_UP) ? -LIM_UP : up_full;

  always_comb begin
    state_d        = state_q;
    item_d         = item_q;
    quo_d          = quo_q;
    idx_d          = idx_q;
    frac_d         = frac_q;
    cos_a_d        = cos_a_q;
    cos_b_d        = cos_b_q;
    gd_a_d         = gd_a_q;
    gd_b_d         = gd_b_q;
    scale_d        = scale_q;
    g_d            = g_q;
    tmp_d          = tmp_q;
    north_d        = north_q;
    east_d         = east_q;
    origin_valid_d = origin_valid_q;
    org_n_d        = org_n_q;
    org_e_d        = org_e_q;
    org_u_d        = org_u_q;
    item_pop_o     = 1'b0;
    mul_start      = 1'b0;
    mul_a          = '0;
    mul_b          = '0;
    out_load       = 1'b0;
    mul_busy_d     = mul_busy_q && !mul_done;
    out_valid_d    = out_valid_q && !m_axis_tready_i;

    case (state_q)
      B_IDLE: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          item_d     = item_i;
          state_d    = B_MPOS;
        end
      end
      // table position = |lat| * 2^POS_W / 90 deg via reciprocal
      B_MPOS: begin
        mul_start = !mul_busy_q;
        mul_a     = POS_RECIP;
        mul_b     = {2'b0, item_q.lat_mag};
        if (mul_done) begin
          quo_d   = mul_p[RECIP_SHIFT +: POS_W];
          state_d = B_ROM0;
        end
      end
      B_ROM0: begin
        idx_d   = (ipos > IDX_MAX) ? IDX_MAX : ipos;
        frac_d  = quo_q[15:0];
        state_d = B_ROM1;
      end
      B_ROM1: state_d = B_ROM2;
      B_ROM2: begin
        cos_a_d = cos_rd_q;
        gd_a_d  = gd_rd_q;
        state_d = B_ROM3;
      end
      B_ROM3: begin
        cos_b_d = cos_rd_q;
        gd_b_d  = gd_rd_q;
        state_d = origin_valid_q ? B_MGD : B_MCOS;
      end
      B_MCOS: begin
        mul_start = !mul_busy_q;
        mul_a     = {32'b0, cdiff};
        mul_b     = {16'b0, frac_q};
        if (mul_done) begin
          scale_d = cos_up ? (cos_a_q + mul_p[47:16]) : (cos_a_q - mul_p[47:16]);
          state_d = B_MGD;
        end
      end
      B_MGD: begin
        mul_start = !mul_busy_q;
        mul_a     = {{(64-GD_W){1'b0}}, gdiff};
        mul_b     = {16'b0, frac_q};
        if (mul_done) begin
          g_d     = gd_up ? (gd_a_q + mul_p[GD_W+15:16]) : (gd_a_q - mul_p[GD_W+15:16]);
          state_d = B_MR;
        end
      end
      B_MR: begin
        mul_start = !mul_busy_q;
        mul_a     = {{(64-GD_W){1'b0}}, g_q};
        mul_b     = {9'b0, EARTH_R_M};
        if (mul_done) begin
          tmp_d   = mul_p[87:24];
          state_d = B_M1K;
        end
      end
      B_M1K: begin
        mul_start = !mul_busy_q;
        mul_a     = tmp_q;
        mul_b     = {22'b0, THOUSAND};
        if (mul_done) begin
          tmp_d   = mul_p[63:0];
          state_d = B_MNS;
        end
      end
      B_MNS: begin
        mul_start = !mul_busy_q;
        mul_a     = tmp_q;
        mul_b     = scale_q;
        if (mul_done) begin
          north_d = ns_sum[16 +: MAG_W];
          state_d = B_MLON;
        end
      end
      B_MLON: begin
        mul_start = !mul_busy_q;
        mul_a     = {32'b0, item_q.lon_mag};
        mul_b     = MM_PER_E7_Q26;
        if (mul_done) begin
          tmp_d   = mul_p[63:0];
          state_d = B_MES;
        end
      end
      B_MES: begin
        mul_start = !mul_busy_q;
        mul_a     = tmp_q;
        mul_b     = scale_q;
        if (mul_done) begin
          east_d  = es_sum[26 +: MAG_W];
          state_d = B_FIN;
        end
      end
      B_FIN: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = B_IDLE;
          if (!origin_valid_q) begin
            origin_valid_d = 1'b1;
            org_n_d        = north_s;
            org_e_d        = east_s;
            org_u_d        = item_q.alt;
          end
        end
      end
      default: state_d = B_IDLE;
    endcase

    if (mul_start) mul_busy_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= B_IDLE;
      origin_valid_q <= 1'b0;
      mul_busy_q     <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      origin_valid_q <= origin_valid_d;
      mul_busy_q     <= mul_busy_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    quo_q    <= quo_d;
    idx_q    <= idx_d;
    frac_q   <= frac_d;
    cos_a_q  <= cos_a_d;
    cos_b_q  <= cos_b_d;
    gd_a_q   <= gd_a_d;
    gd_b_q   <= gd_b_d;
    scale_q  <= scale_d;
    g_q      <= g_d;
    tmp_q    <= tmp_d;
    north_q  <= north_d;
    east_q   <= east_d;
    org_n_q  <= org_n_d;
    org_e_q  <= org_e_d;
    org_u_q  <= org_u_d;
    cos_rd_q <= COS_ROM[rom_addr];
    gd_rd_q  <= GD_ROM[rom_addr];
    if (out_load) begin
      out_right_q <= right_sat[36:0];
      out_fwd_q   <= fwd_sat[36:0];
      out_up_q    <= up_sat[27:0];
      out_first_q <= !origin_valid_q;
      out_oor_q   <= item_q.oor;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, out_fwd_q, out_up_q, out_right_q};
  assign m_axis_tuser_o  = {out_oor_q, out_first_q};

  `GTLM_ASSERT(a_mul_no_overlap, clk_i, rst_ni, !(mul_start && mul_busy_q), "multiplier restarted while busy")
  `GTLM_ASSERT(a_mul_done_busy, clk_i, rst_ni, !mul_done || mul_busy_q, "multiplier done without request")
  `GTLM_ASSERT(a_origin_sticky, clk_i, rst_ni, !$fell(origin_valid_q), "origin lost")
  `GTLM_ASSERT_NEXT(a_origin_latch, clk_i, rst_ni, out_load && !origin_valid_q, origin_valid_q && out_first_q, "origin fix not latched")

endmodule

/* rtl/core/gps_to_local_mercator.sv */
// Top level of the local Mercator projection block.
// Each accepted GPS fix yields one result; the first fix after reset also latches the scale
// and the origin. A fix makes seven passes through the shared 64x32 multiplier, eight for the
// first fix (the first pass scales the latitude to a table position by a reciprocal), besides
// the table reads and the queue, finish and output handoff. A two-entry queue takes new fixes
// while the back end works and a finished result waits in the output register.
module gps_to_local_mercator #(
  parameter int unsigned TABLE_BITS = 10
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [95:0]  s_axis_tdata_i,   // latitude_e7, longitude_e7, altitude_mm
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [103:0] m_axis_tdata_o,   // right_mm, up_mm, forward_mm
  output logic [1:0]   m_axis_tuser_o    // is_origin, out_of_range
);
  import gtlm_pkg::*;

  item_t front_item;
  item_t queue_item;
  logic  front_valid;
  logic  queue_full;
  logic  queue_valid;
  logic  queue_pop;

  gtlm_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .item_valid_o    (front_valid),
    .item_o          (front_item),
    .item_full_i     (queue_full)
  );

  gtlm_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .data_i  (front_item),
    .full_o  (queue_full),
    .valid_o (queue_valid),
    .data_o  (queue_item),
    .pop_i   (queue_pop)
  );

  gtlm_back #(
    .TABLE_BITS (TABLE_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_valid_i    (queue_valid),
    .item_i          (queue_item),
    .item_pop_o      (queue_pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule

/* bench/gps_to_local_mercator_test.sv */
// Self-checking stream testbench for the local Mercator projection block.
module gps_to_local_mercator_test;
  import gtlm_pkg::*;

  localparam int unsigned TB      = 10;
  localparam int unsigned SEGS    = 1 << TB;
  localparam longint      SAT_HOR = 64'sd40100000000;
  localparam longint      SAT_UP  = 64'sd101000000;
  localparam longint      LAT_CAP = 64'sd850511287;

  typedef struct {
    longint right;
    longint up;
    longint fwd;
    bit     origin;
    bit     oor;
  } fix_result_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid_i;
  logic         s_axis_tready_o;
  logic [95:0]  s_axis_tdata_i;   // latitude_e7, longitude_e7, altitude_mm
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i;
  logic [103:0] m_axis_tdata_o;   // right_mm, up_mm, forward_mm
  logic [1:0]   m_axis_tuser_o;   // is_origin, out_of_range

  bit [31:0]   cos_tab [0:SEGS];
  bit [63:0]   gd_tab  [0:SEGS-1];
  bit          org_valid;
  bit [31:0]   merc_scale;
  longint      org_north, org_east, org_up;
  fix_result_t pending_fixes[$];
  int          errors;
  bit          quiet_mode;
  int          stall_left;

  gps_to_local_mercator #(.TABLE_BITS(TB)) i_dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit [63:0] cos_q30(int unsigned m);
    bit [63:0] x, x2, term;
    longint    acc;
    x    = (64'(m) * HALF_PI_Q40) >> (TB + 11);
    x2   = (x * x) >> 30;
    term = 64'd1 << 30;
    acc  = longint'(term);
    for (int unsigned n = 1; n <= 14; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
      if (n % 2 == 1) acc -= longint'(term);
      else            acc += longint'(term);
    end
    if (acc < 0) acc = 0;
    if (acc > longint'(64'd1 << 30)) acc = longint'(64'd1 << 30);
    return 64'(acc);
  endfunction

  function automatic bit [63:0] recip_q20(bit [63:0] c);
    return (64'd1 << 50) / ((c < 64'd1024) ? 64'd1024 : c);
  endfunction

  function automatic bit [63:0] lerp(bit [63:0] a, bit [63:0] b, bit [63:0] f);
    if (b >= a) return a + (((b - a) * f) >> 16);
    return a - (((a - b) * f) >> 16);
  endfunction

  function automatic bit [63:0] mul_shift(bit [63:0] a, bit [63:0] b, int unsigned s);
    return (a >> s) * b + (((a & ((64'd1 << s) - 1)) * b) >> s);
  endfunction

  function automatic longint clip(longint v, longint lim);
    return v > lim ? lim : (v < -lim ? -lim : v);
  endfunction

  task automatic build_tables();
    bit [63:0] h, s, c;
    h = HALF_PI_Q40 >> TB;
    for (int unsigned k = 0; k <= SEGS; k++) begin
      c = cos_q30(2 * k) << 1;
      if (c > (64'd1 << 31)) c = 64'd1 << 31;
      cos_tab[k] = c[31:0];
    end
    gd_tab[0] = 0;
    for (int unsigned k = 0; k + 1 < SEGS; k++) begin
      s = recip_q20(cos_q30(2 * k)) + 4 * recip_q20(cos_q30(2 * k + 1))
        + recip_q20(cos_q30(2 * k + 2));
      gd_tab[k + 1] = gd_tab[k] + (((s * h) / 6) >> 20);
    end
    org_valid = 0;
    merc_scale = 0;
    org_north = 0;
    org_east = 0;
    org_up = 0;
  endtask

  function automatic fix_result_t project_fix(logic [30:0] lat_b, logic [31:0] lon_b,
                                              logic [27:0] alt_b);
    fix_result_t r;
    longint      lat, lon, alt, north, east;
    bit [63:0]   a, pos, f, g, nm, x, em;
    int unsigned idx;
    lat = longint'($signed(lat_b));
    lon = longint'($signed(lon_b));
    alt = longint'($signed(alt_b));
    r.oor = 0;
    r.origin = 0;
    if (lat > LAT_CAP) begin lat = LAT_CAP; r.oor = 1; end
    if (lat < -LAT_CAP) begin lat = -LAT_CAP; r.oor = 1; end
    a   = 64'(lat < 0 ? -lat : lat);
    pos = (a << (TB + 16)) / 64'd900000000;
    idx = int'(pos >> 16);
    if (idx > SEGS - 2) idx = SEGS - 2;
    f = pos & 64'hFFFF;
    if (!org_valid) merc_scale = 32'(lerp(cos_tab[idx], cos_tab[idx + 1], f));
    g  = lerp(gd_tab[idx], gd_tab[idx + 1], f);
    nm = mul_shift(g, 64'd6378137, 24) * 64'd1000;
    nm = (mul_shift(nm, 64'(merc_scale), 31) + 64'd32768) >> 16;
    north = lat < 0 ? -longint'(nm) : longint'(nm);
    x  = 64'(lon < 0 ? -lon : lon) * 64'(MM_PER_E7_Q26);
    em = (mul_shift(x, 64'(merc_scale), 31) + (64'd1 << 25)) >> 26;
    east = lon < 0 ? -longint'(em) : longint'(em);
    if (!org_valid) begin
      org_north = north;
      org_east  = east;
      org_up    = alt;
      org_valid = 1;
      r.origin  = 1;
    end
    r.right = clip(org_north - north, SAT_HOR);
    r.fwd   = clip(east - org_east, SAT_HOR);
    r.up    = clip(alt - org_up, SAT_UP);
    return r;
  endfunction

  function automatic int pick_gap();
    if (quiet_mode) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_fix(logic [30:0] lat, logic [31:0] lon, logic [27:0] alt);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata_i  <= {5'b0, alt, lon, lat};
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_fixes.push_back(project_fix(lat, lon, alt));
  endtask

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", field, got, want);
    errors++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready_i <= 1'b0;
      end else if (!quiet_mode && $urandom_range(0, 9) < 3) begin
        stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(10, 60);
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    fix_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_fixes.size() == 0) begin
        report_mismatch("unexpected transfer", 0, 0);
      end else begin
        want = pending_fixes.pop_front();
        if (longint'($signed(m_axis_tdata_o[36:0])) != want.right)
          report_mismatch("right_mm", longint'($signed(m_axis_tdata_o[36:0])), want.right);
        if (longint'($signed(m_axis_tdata_o[64:37])) != want.up)
          report_mismatch("up_mm", longint'($signed(m_axis_tdata_o[64:37])), want.up);
        if (longint'($signed(m_axis_tdata_o[101:65])) != want.fwd)
          report_mismatch("forward_mm", longint'($signed(m_axis_tdata_o[101:65])), want.fwd);
        if (m_axis_tuser_o[0] != want.origin)
          report_mismatch("is_origin", m_axis_tuser_o[0], want.origin);
        if (m_axis_tuser_o[1] != want.oor)
          report_mismatch("out_of_range", m_axis_tuser_o[1], want.oor);
      end
    end
  end

  // origin on the equator so the scale is near one and saturation can be reached
  task automatic test_origin();
    send_fix(31'sd0, -32'sd1800000000, 28'sd0);
    send_fix(31'sd0, -32'sd1800000000, 28'sd0);
    send_fix(31'sd1000, -32'sd1799999000, 28'sd1500);
  endtask

  task automatic test_latitude_edges();
    send_fix(31'sd850511287, 32'sd0, 28'sd0);
    send_fix(-31'sd850511287, 32'sd0, 28'sd0);
    send_fix(31'sd850511288, 32'sd0, 28'sd0);
    send_fix(-31'sd850511288, 32'sd0, 28'sd0);
    send_fix(31'sd900000000, 32'sd5, 28'sd7);
    send_fix(-31'sd900000000, -32'sd5, -28'sd7);
    send_fix(31'h3FFFFFFF, 32'sd0, 28'sd0);
    send_fix(31'h40000000, 32'sd0, 28'sd0);
    send_fix(31'sd899999999, 32'sd1, 28'sd1);
    send_fix(31'sd1, 32'sd0, 28'sd0);
    send_fix(-31'sd1, 32'sd0, 28'sd0);
  endtask

  task automatic test_longitude_edges();
    send_fix(31'sd0, 32'sd1800000000, 28'sd0);
    send_fix(31'sd0, 32'h7FFFFFFF, 28'sd0);
    send_fix(31'sd0, 32'h80000000, 28'sd0);
    send_fix(31'sd450000000, 32'h7FFFFFFF, 28'sd0);
    send_fix(-31'sd850511287, 32'sd1800000000, 28'sd0);
  endtask

  task automatic test_altitude_edges();
    send_fix(31'sd0, 32'sd0, 28'h7FFFFFF);
    send_fix(31'sd0, 32'sd0, 28'h8000000);
    send_fix(31'sd0, 32'sd0, 28'sd100000000);
    send_fix(31'sd0, 32'sd0, -28'sd1000000);
  endtask

  task automatic test_random(int count);
    logic [30:0] lat;
    logic [31:0] lon;
    logic [27:0] alt;
    int          mode;
    for (int n = 0; n < count; n++) begin
      if (n % 150 == 0) quiet_mode = (n % 300 == 150);
      mode = $urandom_range(0, 9);
      if (mode < 5) begin
        lat = 31'($signed($urandom_range(0, 2000000)) - 1000000);
        lon = 32'($signed($urandom_range(0, 2000000)) - 1800000000 - 1000000);
        alt = 28'($urandom_range(0, 200000));
      end else if (mode < 8) begin
        lat = 31'($signed($urandom_range(0, 1701022574)) - 850511287);
        lon = 32'($signed($urandom_range(0, 3600000000)) - 1800000000);
        alt = 28'($signed($urandom_range(0, 101000000)) - 1000000);
      end else begin
        lat = 31'($urandom);
        lon = $urandom;
        alt = 28'($urandom);
      end
      send_fix(lat, lon, alt);
    end
    quiet_mode = 0;
  endtask

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    m_axis_tready_i = 1'b0;
    errors          = 0;
    quiet_mode      = 0;
    stall_left      = 0;
    build_tables();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_origin();
    test_latitude_edges();
    test_longitude_edges();
    test_altitude_edges();
    test_random(600);
    s_axis_tvalid_i <= 1'b0;
    while (pending_fixes.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #20000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/gtlm_pkg.sv
rtl/core/gtlm_front.sv
rtl/core/gtlm_fifo.sv
rtl/core/gtlm_mul.sv
rtl/core/gtlm_back.sv
rtl/core/gps_to_local_mercator.sv
bench/gps_to_local_mercator_test.sv
